// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk_i and disabled while rst_ni low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define OLS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Expression must never be true outside reset.
`define OLS_ASSERT_NEVER(name, expr, msg) \
  `OLS_ASSERT(name, !(expr), msg)

`endif

// ----- rtl/core/ols_pkg.sv -----
// ----------------------------------------------------------------------------
// ols_pkg
// Types, sizes and request codes shared by the ordered list store.
// ----------------------------------------------------------------------------
package ols_pkg;

  localparam int CAPACITY   = 16;
  localparam int VALUE_BITS = 32;

  // Request field widths
  localparam int FUNC_W  = 4;
  localparam int POS_W   = 5;
  localparam int VAL_W   = 32;
  localparam int FOUND_W = 4;
  localparam int COUNT_W = 5;

  // Stored word: the request value carries 32 bits at most
  localparam int STORE_BITS = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [FUNC_W-1:0] {
    FN_CLEAR     = 4'd0,
    FN_INS_HEAD  = 4'd1,
    FN_INS_TAIL  = 4'd2,
    FN_INS_AT    = 4'd3,
    FN_DEL_HEAD  = 4'd4,
    FN_DEL_TAIL  = 4'd5,
    FN_DEL_AT    = 4'd6,
    FN_DEL_FIRST = 4'd7,
    FN_DEL_ALL   = 4'd8,
    FN_FIND      = 4'd9,
    FN_COUNT     = 4'd10
  } func_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL_AT,
    CELL_DEL_HIT
  } cell_op_e;

  typedef enum logic {
    S_IDLE,
    S_PURGE
  } seq_state_e;

  // Broadcast from the sequencer to every cell
  typedef struct packed {
    cell_op_e              op;
    logic [IDX_W-1:0]      pos;
    logic [CNT_W-1:0]      count;
    logic [STORE_BITS-1:0] value;
  } cell_cmd_t;

  // Match status gathered from the chain
  typedef struct packed {
    logic             any_hit;
    logic [IDX_W-1:0] first_idx;
  } chain_stat_t;

endpackage

// ----- rtl/core/ols_req_if.sv -----
// ----------------------------------------------------------------------------
// ols_req_if
// Request channel: valid/ready with func, position and value.
// ----------------------------------------------------------------------------
interface ols_req_if;
  import ols_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic [POS_W-1:0]         position;
  logic signed [VAL_W-1:0]  value;

  modport source (output valid, output func, output position, output value, input ready);
  modport sink   (input valid, input func, input position, input value, output ready);
endinterface

// ----- rtl/core/ols_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ols_rsp_if
// Response channel: valid/ready with ok, found_index and count.
// ----------------------------------------------------------------------------
interface ols_rsp_if;
  import ols_pkg::*;

  logic               valid;
  logic               ready;
  logic               ok;
  logic [FOUND_W-1:0] found_index;
  logic [COUNT_W-1:0] count;

  modport source (output valid, output ok, output found_index, output count, input ready);
  modport sink   (input valid, input ok, input found_index, input count, output ready);
endinterface

// ----- rtl/core/ols_cell.sv -----
// ----------------------------------------------------------------------------
// ols_cell
// One list slot: holds a word, compares it, shifts with its neighbors.
// ----------------------------------------------------------------------------
module ols_cell import ols_pkg::*; (
  input  logic                  clk_i,
  input  logic [IDX_W-1:0]      idx_i,
  input  cell_cmd_t             cmd_i,
  input  logic [STORE_BITS-1:0] left_i,
  input  logic [STORE_BITS-1:0] right_i,
  input  logic                  seen_i,
  output logic [STORE_BITS-1:0] data_o,
  output logic                  hit_o,
  output logic                  seen_o
);

  logic [STORE_BITS-1:0] data_q, data_d;
  logic                  occupied;

  assign occupied = CNT_W'(idx_i) < cmd_i.count;
  assign hit_o    = occupied && (data_q == cmd_i.value);
  assign seen_o   = seen_i | hit_o;
  assign data_o   = data_q;

  always_comb begin
    data_d = data_q;
    case (cmd_i.op)
      CELL_INS: begin
        if (idx_i > cmd_i.pos) begin
          data_d = left_i;
        end else if (idx_i == cmd_i.pos) begin
          data_d = cmd_i.value;
        end
      end
      CELL_DEL_AT: begin
        if (idx_i >= cmd_i.pos) begin
          data_d = right_i;
        end
      end
      // first match and everything behind it move up one slot
      CELL_DEL_HIT: begin
        if (seen_o) begin
          data_d = right_i;
        end
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

// ----- rtl/core/ols_seq.sv -----
// ----------------------------------------------------------------------------
// ols_seq
// Request decode, occupancy count, delete-all loop and response register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ols_seq import ols_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ols_req_if.sink     req_i,
  ols_rsp_if.source   rsp_o,
  input  chain_stat_t stat_i,
  output cell_cmd_t   cmd_o
);

  seq_state_e            state_q, state_d;
  logic [CNT_W-1:0]      occ_q, occ_d;
  logic [STORE_BITS-1:0] purge_val_q;
  logic                  rsp_valid_q;
  logic                  rsp_ok_q, rsp_ok_d;
  logic [FOUND_W-1:0]    rsp_found_q, rsp_found_d;
  logic [COUNT_W-1:0]    rsp_count_q;
  logic                  rsp_load;
  logic                  fire;
  logic                  full;
  logic [CMP_W-1:0]      pos_ext, occ_ext;
  func_e                 func;

  assign func        = func_e'(req_i.func);
  assign req_i.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign fire        = req_i.valid && req_i.ready;
  assign full        = occ_q == CNT_W'(CAPACITY);
  assign pos_ext     = CMP_W'(req_i.position);
  assign occ_ext     = CMP_W'(occ_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (fire && func == FN_DEL_ALL && occ_q != '0) begin
          state_d = S_PURGE;
        end
      end
      S_PURGE: begin
        if (!stat_i.any_hit) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Outputs: cell command, new occupancy, response
  always_comb begin
    cmd_o.op    = CELL_HOLD;
    cmd_o.pos   = '0;
    cmd_o.count = occ_q;
    cmd_o.value = (state_q == S_PURGE) ? purge_val_q : req_i.value[STORE_BITS-1:0];
    occ_d       = occ_q;
    rsp_load    = 1'b0;
    rsp_ok_d    = 1'b0;
    rsp_found_d = '0;
    case (state_q)
      S_IDLE: begin
        if (fire) begin
          rsp_load = 1'b1;
          case (func)
            FN_CLEAR: begin
              occ_d    = '0;
              rsp_ok_d = 1'b1;
            end
            FN_INS_HEAD: begin
              if (!full) begin
                cmd_o.op = CELL_INS;
                occ_d    = occ_q + CNT_W'(1);
                rsp_ok_d = 1'b1;
              end
            end
            FN_INS_TAIL: begin
              if (!full) begin
                cmd_o.op  = CELL_INS;
                cmd_o.pos = IDX_W'(occ_q);
                occ_d     = occ_q + CNT_W'(1);
                rsp_ok_d  = 1'b1;
              end
            end
            FN_INS_AT: begin
              if (pos_ext <= occ_ext && !full) begin
                cmd_o.op  = CELL_INS;
                cmd_o.pos = IDX_W'(req_i.position);
                occ_d     = occ_q + CNT_W'(1);
                rsp_ok_d  = 1'b1;
              end
            end
            FN_DEL_HEAD: begin
              if (occ_q != '0) begin
                cmd_o.op = CELL_DEL_AT;
                occ_d    = occ_q - CNT_W'(1);
                rsp_ok_d = 1'b1;
              end
            end
            FN_DEL_TAIL: begin
              if (occ_q != '0) begin
                occ_d    = occ_q - CNT_W'(1);
                rsp_ok_d = 1'b1;
              end
            end
            FN_DEL_AT: begin
              if (pos_ext < occ_ext) begin
                cmd_o.op  = CELL_DEL_AT;
                cmd_o.pos = IDX_W'(req_i.position);
                occ_d     = occ_q - CNT_W'(1);
                rsp_ok_d  = 1'b1;
              end
            end
            FN_DEL_FIRST: begin
              if (stat_i.any_hit) begin
                cmd_o.op = CELL_DEL_HIT;
                occ_d    = occ_q - CNT_W'(1);
                rsp_ok_d = 1'b1;
              end
            end
            FN_DEL_ALL: begin
              // empty list answers at once; otherwise hand over to the loop
              if (occ_q != '0) begin
                rsp_load = 1'b0;
              end
            end
            FN_FIND: begin
              if (stat_i.any_hit) begin
                rsp_ok_d    = 1'b1;
                rsp_found_d = FOUND_W'(stat_i.first_idx);
              end
            end
            FN_COUNT: begin
              rsp_ok_d = 1'b1;
            end
            default: begin
              rsp_ok_d = 1'b0;
            end
          endcase
        end
      end
      S_PURGE: begin
        // drop one match per cycle until none is left
        if (stat_i.any_hit) begin
          cmd_o.op = CELL_DEL_HIT;
          occ_d    = occ_q - CNT_W'(1);
        end else begin
          rsp_load = 1'b1;
          rsp_ok_d = 1'b1;
        end
      end
      default: begin
        rsp_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      purge_val_q <= req_i.value[STORE_BITS-1:0];
    end
    if (rsp_load) begin
      rsp_ok_q    <= rsp_ok_d;
      rsp_found_q <= rsp_found_d;
      rsp_count_q <= COUNT_W'(occ_d);
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.ok          = rsp_ok_q;
  assign rsp_o.found_index = rsp_found_q;
  assign rsp_o.count       = rsp_count_q;

  `OLS_ASSERT(a_occ_bound, occ_q <= CNT_W'(CAPACITY), "occupancy above capacity")
  `OLS_ASSERT(a_purge_blocks, (state_q == S_PURGE) |-> !req_i.ready, "request taken during purge")
  `OLS_ASSERT_NEVER(a_hit_empty, stat_i.any_hit && occ_q == '0, "match in an empty list")

endmodule

// ----- rtl/core/ordered_list_store_core.sv -----
// ----------------------------------------------------------------------------
// ordered_list_store_core
// Bounded ordered list of signed words kept in a shifting chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request per transfer: func, position and value.
//   rsp_o returns exactly one transfer per request: ok, found_index, count.
//   Position 0 is the head. Each cell holds one slot and moves its word to a
//   neighbor on insert or delete, so all slots shift together in the same cycle.
// Latency and throughput:
//   Most requests are done in the cycle they are taken; the result is
//   registered and shows on rsp_o in the next cycle. A new request is taken
//   every cycle while the result register drains.
//   Delete-all-matches removes one match per cycle through the cell chain
//   until none is left, then answers; req_i stays low meanwhile.
// Reset:
//   The list comes out of reset empty; cell contents are not cleared, since
//   slots at or past the count are never read.
// Stall:
//   While rsp_o waits on ready, one finished result is held; req_i drops
//   until that result is transferred or is being transferred.
// ----------------------------------------------------------------------------
module ordered_list_store_core import ols_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ols_req_if.sink   req_i,
  ols_rsp_if.source rsp_o
);

  cell_cmd_t                          cmd;
  chain_stat_t                        stat;
  logic [CAPACITY-1:0][STORE_BITS-1:0] cell_data;
  logic [CAPACITY-1:0]                cell_hit;
  logic [CAPACITY:0]                  seen;
  logic [IDX_W-1:0]                   first_idx;

  // Sequencer: decode, occupancy, purge loop and result register
  ols_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // Chain of slots; the match flag ripples from head to tail
  assign seen[0] = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [STORE_BITS-1:0] left_w, right_w;

    if (g == 0) begin : g_head
      assign left_w = '0;
    end else begin : g_left
      assign left_w = cell_data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_data[g+1];
    end

    ols_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(g)),
      .cmd_i   (cmd),
      .left_i  (left_w),
      .right_i (right_w),
      .seen_i  (seen[g]),
      .data_o  (cell_data[g]),
      .hit_o   (cell_hit[g]),
      .seen_o  (seen[g+1])
    );
  end

  // Encode the first matching slot: at most one cell sees a hit with no
  // earlier hit, so an OR of the gated indexes gives its position
  always_comb begin
    first_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_hit[i] && !seen[i]) begin
        first_idx = first_idx | IDX_W'(i);
      end
    end
  end

  assign stat.any_hit   = seen[CAPACITY];
  assign stat.first_idx = first_idx;

endmodule
